// ----- rtl/mld_pkg.sv -----
// ----------------------------------------------------------------------------
// mld_pkg
// Shared widths, reset values, register codes, stage types and the glyph
// table of the light-driven Morse decoder.
// ----------------------------------------------------------------------------
package mld_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int THR_W        = 12;
  localparam int UNIT_W       = 10;
  localparam int TOL_W        = 6;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int CHAR_W       = 7;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 8;

  localparam int MAX_SYMBOLS_DEF = 6;
  localparam int COUNT_BITS_DEF  = 16;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1000);
  localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(90);
  localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(15);

  // unit * tolerance, then 1x, 3x and 7x of it, then /100 by reciprocal
  localparam int PROD_W      = UNIT_W + TOL_W;
  localparam int X_W         = PROD_W + 3;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((64'd1 << RECIP_SHIFT) / 100 + 1);
  localparam int MUL_W       = X_W + RECIP_W;
  localparam int WIN_W       = UNIT_W + 3;

  // busy countdown loaded on reset and on a register write while the windows settle
  localparam logic [1:0] WIN_LATENCY = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_QMARK = CHAR_W'(8'h3F);
  localparam logic [CHAR_W-1:0] CHAR_SPACE = CHAR_W'(8'h20);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_UNIT      = 2'd1,
    REG_TOLERANCE = 2'd2
  } mld_reg_e;

  typedef struct packed {
    logic [WIN_W-1:0] lo1;
    logic [WIN_W-1:0] hi1;
    logic [WIN_W-1:0] lo3;
    logic [WIN_W-1:0] hi3;
    logic [WIN_W-1:0] lo7;
  } mld_win_t;

  typedef struct packed {
    logic              push;
    logic              two;
    logic [CHAR_W-1:0] ch;
  } mld_res_t;

  // bit i of bits set means symbol i is a dash
  function automatic logic [CHAR_W-1:0] decode_glyph(input logic [3:0] cnt,
                                                     input logic [7:0] bits);
    logic [CHAR_W-1:0] ch;
    ch = CHAR_QMARK;
    case (cnt)
      4'd1: begin
        case (bits[0])
          1'b0:    ch = CHAR_W'("E");
          default: ch = CHAR_W'("T");
        endcase
      end
      4'd2: begin
        case (bits[1:0])
          2'b10:   ch = CHAR_W'("A");
          2'b00:   ch = CHAR_W'("I");
          2'b11:   ch = CHAR_W'("M");
          default: ch = CHAR_W'("N");
        endcase
      end
      4'd3: begin
        case (bits[2:0])
          3'b001:  ch = CHAR_W'("D");
          3'b011:  ch = CHAR_W'("G");
          3'b101:  ch = CHAR_W'("K");
          3'b111:  ch = CHAR_W'("O");
          3'b010:  ch = CHAR_W'("R");
          3'b000:  ch = CHAR_W'("S");
          3'b100:  ch = CHAR_W'("U");
          default: ch = CHAR_W'("W");
        endcase
      end
      4'd4: begin
        case (bits[3:0])
          4'b0001: ch = CHAR_W'("B");
          4'b0101: ch = CHAR_W'("C");
          4'b0100: ch = CHAR_W'("F");
          4'b0000: ch = CHAR_W'("H");
          4'b1110: ch = CHAR_W'("J");
          4'b0010: ch = CHAR_W'("L");
          4'b0110: ch = CHAR_W'("P");
          4'b1011: ch = CHAR_W'("Q");
          4'b1000: ch = CHAR_W'("V");
          4'b1001: ch = CHAR_W'("X");
          4'b1101: ch = CHAR_W'("Y");
          4'b0011: ch = CHAR_W'("Z");
          default: ch = CHAR_QMARK;
        endcase
      end
      4'd5: begin
        case (bits[4:0])
          5'b11111: ch = CHAR_W'("0");
          5'b11110: ch = CHAR_W'("1");
          5'b11100: ch = CHAR_W'("2");
          5'b11000: ch = CHAR_W'("3");
          5'b10000: ch = CHAR_W'("4");
          5'b00000: ch = CHAR_W'("5");
          5'b00001: ch = CHAR_W'("6");
          5'b00011: ch = CHAR_W'("7");
          5'b00111: ch = CHAR_W'("8");
          5'b01111: ch = CHAR_W'("9");
          default:  ch = CHAR_QMARK;
        endcase
      end
      default: ch = CHAR_QMARK;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/mld_cfg.sv -----
// ----------------------------------------------------------------------------
// mld_cfg
// Configuration registers and the three-stage derivation of the duration
// windows; busy holds off input so that no later sample meets older windows.
// ----------------------------------------------------------------------------
module mld_cfg
  import mld_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [THR_W-1:0]      thr_o,
  output mld_win_t              win_o,
  output logic                  busy_o
);

  logic [THR_W-1:0]  thr_q;
  logic [UNIT_W-1:0] unit_q;
  logic [TOL_W-1:0]  tol_q;
  logic [1:0]        busy_cnt_q;

  logic [PROD_W-1:0] prod_q;
  logic [WIN_W-1:0]  q1_q, q3_q, q7_q;
  mld_win_t          win_q;

  logic [X_W-1:0]    x1, x3, x7;
  logic [MUL_W-1:0]  m1, m3, m7;
  logic [WIN_W-1:0]  n1, n3, n7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THR_RESET;
      unit_q     <= UNIT_RESET;
      tol_q      <= TOL_RESET;
      busy_cnt_q <= WIN_LATENCY;
    end else begin
      if (cfg_we_i) begin
        busy_cnt_q <= WIN_LATENCY;
        case (mld_reg_e'(cfg_idx_i))
          REG_THRESHOLD: thr_q  <= cfg_data_i[THR_W-1:0];
          REG_UNIT:      unit_q <= cfg_data_i[UNIT_W-1:0];
          REG_TOLERANCE: tol_q  <= cfg_data_i[TOL_W-1:0];
          default: ;
        endcase
      end else if (busy_cnt_q != 2'd0) begin
        busy_cnt_q <= busy_cnt_q - 2'd1;
      end
    end
  end

  always_comb begin
    x1 = X_W'(prod_q);
    x3 = (x1 << 1) + x1;
    x7 = (x1 << 3) - x1;
    m1 = MUL_W'(x1) * MUL_W'(RECIP_100);
    m3 = MUL_W'(x3) * MUL_W'(RECIP_100);
    m7 = MUL_W'(x7) * MUL_W'(RECIP_100);
    n1 = WIN_W'(unit_q);
    n3 = (n1 << 1) + n1;
    n7 = (n1 << 3) - n1;
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= PROD_W'(unit_q) * PROD_W'(tol_q);
    q1_q      <= WIN_W'(m1 >> RECIP_SHIFT);
    q3_q      <= WIN_W'(m3 >> RECIP_SHIFT);
    q7_q      <= WIN_W'(m7 >> RECIP_SHIFT);
    win_q.lo1 <= n1 - q1_q;
    win_q.hi1 <= n1 + q1_q;
    win_q.lo3 <= n3 - q3_q;
    win_q.hi3 <= n3 + q3_q;
    win_q.lo7 <= n7 - q7_q;
  end

  assign thr_o  = thr_q;
  assign win_o  = win_q;
  assign busy_o = (busy_cnt_q != 2'd0);

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy_o)
    else $error("windows not held busy after a register write");

endmodule

// ----- rtl/mld_core.sv -----
// ----------------------------------------------------------------------------
// mld_core
// Input register, light/duration classification, symbol buffer and glyph
// lookup; one tick is resolved per cycle unless the output or busy stalls it.
// ----------------------------------------------------------------------------
module mld_core
  import mld_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [SAMPLE_W-1:0] in_sample_i,
  output logic                in_ready_o,
  input  logic [THR_W-1:0]    thr_i,
  input  mld_win_t            win_i,
  input  logic                busy_i,
  input  logic                out_free_i,
  output mld_res_t            res_o
);

  localparam int SYM_CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int CMP_W     = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;

  logic                   in_valid_q;
  logic [SAMPLE_W-1:0]    sample_q;
  logic                   light_on_q;
  logic [COUNT_BITS-1:0]  elapsed_q, elapsed_d, elapsed_base;
  logic [MAX_SYMBOLS-1:0] sym_bits_q, sym_bits_d;
  logic [SYM_CNT_W-1:0]   sym_cnt_q, sym_cnt_d;

  logic             now_on, change, adv, accept;
  logic [CMP_W-1:0] dur;
  logic             in1, in3, ge7;
  logic             letter, word, emit, add_sym, dash;

  always_comb begin
    now_on  = sample_q > thr_i;
    change  = now_on != light_on_q;
    dur     = CMP_W'(elapsed_q);
    in1     = (dur >= CMP_W'(win_i.lo1)) && (dur <= CMP_W'(win_i.hi1));
    in3     = (dur >= CMP_W'(win_i.lo3)) && (dur <= CMP_W'(win_i.hi3));
    ge7     = dur >= CMP_W'(win_i.lo7);
    letter  = change && now_on && in3;
    word    = change && now_on && !in3 && ge7;
    emit    = letter || word;
    dash    = !in1;
    add_sym = change && !now_on && (in1 || in3)
              && (sym_cnt_q < SYM_CNT_W'(MAX_SYMBOLS));

    adv        = in_valid_q && (!emit || out_free_i);
    in_ready_o = !busy_i && (!in_valid_q || adv);
    accept     = in_valid_i && in_ready_o;

    res_o.push = adv && emit;
    res_o.two  = word;
    res_o.ch   = decode_glyph(4'(sym_cnt_q), 8'(sym_bits_q));

    elapsed_base = change ? '0 : elapsed_q;
    elapsed_d    = (elapsed_base != '1) ? elapsed_base + COUNT_BITS'(1) : elapsed_base;

    sym_bits_d = sym_bits_q;
    sym_cnt_d  = sym_cnt_q;
    if (emit) begin
      sym_bits_d = '0;
      sym_cnt_d  = '0;
    end else if (add_sym) begin
      sym_bits_d = sym_bits_q | (MAX_SYMBOLS'(dash) << sym_cnt_q);
      sym_cnt_d  = sym_cnt_q + SYM_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      light_on_q <= 1'b0;
      elapsed_q  <= '0;
      sym_bits_q <= '0;
      sym_cnt_q  <= '0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        light_on_q <= now_on;
        elapsed_q  <= elapsed_d;
        sym_bits_q <= sym_bits_d;
        sym_cnt_q  <= sym_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_sample_i;
    end
  end

  a_sym_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_cnt_q <= SYM_CNT_W'(MAX_SYMBOLS))
    else $error("symbol buffer overfilled");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> $stable(elapsed_q) && $stable(sym_cnt_q))
    else $error("tick state moved while the tick was stalled");

endmodule

// ----- rtl/mld_out.sv -----
// ----------------------------------------------------------------------------
// mld_out
// Result register with one pending space slot for word gaps.
// ----------------------------------------------------------------------------
module mld_out
  import mld_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mld_res_t          res_i,
  output logic              out_free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              out_last_o
);

  logic              valid_q;
  logic              pend_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic              drain;

  assign drain      = valid_q && out_ready_i;
  assign out_free_o = !valid_q || (out_ready_i && !pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      if (res_i.push) begin
        valid_q <= 1'b1;
        pend_q  <= res_i.two;
      end else if (drain) begin
        if (pend_q) begin
          pend_q <= 1'b0;
        end else begin
          valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.push) begin
      char_q <= res_i.ch;
      last_q <= !res_i.two;
    end else if (drain && pend_q) begin
      char_q <= CHAR_SPACE;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  a_pend_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> valid_q)
    else $error("space pending without a character shown");

  a_push_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.push |-> (!valid_q || (out_ready_i && !pend_q)))
    else $error("result pushed over an undelivered result");

endmodule

// ----- rtl/morse_light_decoder.sv -----
// ----------------------------------------------------------------------------
// morse_light_decoder
// A tick's result goes through the sample register, then the result register.
// Throughput: one tick per cycle unless stalled; word gaps add a space beat.
// After a register write (and after reset) input is held off while the
// window pipeline (multiply, reciprocal divide, bounds) settles.
// Reset: asynchronous, active low; registers return to 1000, 90 and 15.
// ----------------------------------------------------------------------------
module morse_light_decoder
  import mld_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [11:0] light_sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [6:0] out_char
  output logic                   m_axis_tlast
);

  logic [THR_W-1:0]  thr;
  mld_win_t          win;
  logic              busy;
  logic              out_free;
  mld_res_t          res;
  logic [CHAR_W-1:0] out_char;

  mld_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .thr_o      (thr),
    .win_o      (win),
    .busy_o     (busy)
  );

  mld_core #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_sample_i (s_axis_tdata[SAMPLE_W-1:0]),
    .in_ready_o  (s_axis_tready),
    .thr_i       (thr),
    .win_i       (win),
    .busy_i      (busy),
    .out_free_i  (out_free),
    .res_o       (res)
  );

  mld_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_W'(out_char);

endmodule
